### src/byte_memory_with_sized_access_macros.svh
`ifndef BYTE_MEMORY_WITH_SIZED_ACCESS_MACROS_SVH
`define BYTE_MEMORY_WITH_SIZED_ACCESS_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define BMA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define BMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bma_pkg.sv
`timescale 1ns / 1ps

package bma_pkg;

   localparam int MEM_BYTES_DEFAULT = 4096;

   localparam logic [2:0] OP_RD_BYTE  = 3'd0;
   localparam logic [2:0] OP_RD_HALF  = 3'd1;
   localparam logic [2:0] OP_RD_WORD  = 3'd2;
   localparam logic [2:0] OP_WR_BYTE  = 3'd3;
   localparam logic [2:0] OP_WR_HALF  = 3'd4;
   localparam logic [2:0] OP_WR_WORD  = 3'd5;
   localparam logic [2:0] OP_CHECKSUM = 3'd6;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_OOB        = 2'd1;
   localparam logic [1:0] STAT_MISALIGNED = 2'd2;

   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] addr_in;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sum_ctl_type;

endpackage

### src/bma_ram.sv
`timescale 1ns / 1ps

module bma_ram
   import bma_pkg::*;
#(
   parameter int ROWS = MEM_BYTES_DEFAULT / 4,
   parameter int RW   = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [RW-1:0] wr_row,
   input  logic [3:0]    wr_be,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [RW-1:0] rd_row,
   output logic [31:0]   rd_data
);

   logic [3:0][7:0] mem_ff [ROWS];
   logic [31:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         if (wr_en && wr_be[j]) begin
            mem_ff[wr_row][j] <= wr_data[8*j +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bma_sum.sv
`timescale 1ns / 1ps

`include "byte_memory_with_sized_access_macros.svh"

module bma_sum
   import bma_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT,
   parameter int ROWS      = MEM_BYTES_DEFAULT / 4,
   parameter int RW        = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   rd_data,
   output logic          rd_en,
   output logic [RW-1:0] rd_row,
   output sum_ctl_type   ctl,
   output logic [31:0]   sum
);

   localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   logic          issuing_ff,    issuing_in;
   logic [RW-1:0] issue_row_ff,  issue_row_in;
   logic          data_valid_ff, data_valid_in;
   logic          data_last_ff,  data_last_in;
   logic [RW-1:0] data_row_ff,   data_row_in;
   logic          rsum_valid_ff, rsum_valid_in;
   logic          rsum_last_ff,  rsum_last_in;
   logic [31:0]   rsum_ff,       rsum_in;
   logic [31:0]   acc_ff,        acc_in;
   logic [31:0]   base;

   always_comb begin
      logic [31:0] addr_k;
      issuing_in   = issuing_ff;
      issue_row_in = issue_row_ff;
      if (start) begin
         issuing_in   = 1'b1;
         issue_row_in = '0;
      end else if (issuing_ff) begin
         issue_row_in = issue_row_ff + RW'(1);
         if (issue_row_ff == LAST_ROW) begin
            issuing_in = 1'b0;
         end
      end

      data_valid_in = issuing_ff;
      data_last_in  = issuing_ff && (issue_row_ff == LAST_ROW);
      data_row_in   = issue_row_ff;

      base    = 32'({data_row_ff, 2'b00});
      rsum_in = '0;
      for (int k = 0; k < 4; k++) begin
         addr_k = base | 32'(k);
         if (addr_k < MEM_LIMIT) begin
            rsum_in = rsum_in + (addr_k ^ {24'd0, rd_data[8*(3-k) +: 8]});
         end
      end
      rsum_valid_in = data_valid_ff;
      rsum_last_in  = data_valid_ff && data_last_ff;

      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (rsum_valid_ff) begin
         acc_in = acc_ff + rsum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff    <= 1'b0;
         data_valid_ff <= 1'b0;
         rsum_valid_ff <= 1'b0;
      end else begin
         issuing_ff    <= issuing_in;
         data_valid_ff <= data_valid_in;
         rsum_valid_ff <= rsum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_row_ff <= issue_row_in;
      data_last_ff <= data_last_in;
      data_row_ff  <= data_row_in;
      rsum_last_ff <= rsum_last_in;
      rsum_ff      <= rsum_in;
      acc_ff       <= acc_in;
   end

   assign rd_en  = issuing_ff;
   assign rd_row = issue_row_ff;
   assign ctl    = '{busy: issuing_ff || data_valid_ff || rsum_valid_ff,
                     done: rsum_valid_ff && rsum_last_ff};
   assign sum    = acc_ff + rsum_ff;

   `BMA_ASSERT_NEXT(a_start_issues, start, rd_en && (rd_row == '0), "sweep did not begin")
   `BMA_ASSERT_NOW(a_done_drained, ctl.done, !issuing_ff && !data_valid_ff, "done before drain")
   `BMA_ASSERT_NOW(a_no_restart, start, !ctl.busy, "start while sweep in flight")

endmodule

### src/byte_memory_with_sized_access.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req_      in   req_valid/req_ready    req_type: opcode, addr_in, write_value
// rsp_      out  rsp_valid/rsp_ready    rsp_type: read_value, status
//
// Writes, rejected accesses and the unused opcode are answered in the cycle after they are taken;
// a read first passes the registered read of the word-wide memory and the S_READ state.
// A checksum sweeps one memory row of 4 bytes per cycle.
// After reset a clearing pass writes zero to every row, ROWS = ceil(MEM_BYTES / 4) rows,
// with req_ready low. A held response stalls the next transaction;
// the output register frees the request side in the same cycle that the response is taken.

`include "byte_memory_with_sized_access_macros.svh"

module byte_memory_with_sized_access
   import bma_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int ROWS = (MEM_BYTES + 3) / 4;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [31:0]   MEM_LIMIT = 32'(MEM_BYTES);
   localparam logic [31:0]   LIM_HALF  = 32'(MEM_BYTES - 2);
   localparam logic [31:0]   LIM_WORD  = 32'(MEM_BYTES - 4);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_SUM   = 4'b1000
   } state_type;

   state_type     state_ff,     state_in;
   logic [RW-1:0] clear_row_ff, clear_row_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff, rsp_payload_in;
   logic [1:0]    rd_size_ff,   rd_size_in;
   logic [1:0]    rd_off_ff,    rd_off_in;

   logic          req_fire;
   logic          is_rd, is_wr, is_half, is_word, is_sum;
   logic [1:0]    acc_status;
   logic [1:0]    lane;
   logic [3:0]    acc_be;
   logic [31:0]   acc_data;
   logic [31:0]   rd_value;

   logic          ram_wr_en;
   logic [RW-1:0] ram_wr_row;
   logic [3:0]    ram_wr_be;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [RW-1:0] ram_rd_row;
   logic [31:0]   ram_rd_data;

   logic          sum_start;
   logic          sum_rd_en;
   logic [RW-1:0] sum_rd_row;
   sum_ctl_type   sum_ctl;
   logic [31:0]   sum_value;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      is_rd   = req_payload.opcode inside {OP_RD_BYTE, OP_RD_HALF, OP_RD_WORD};
      is_wr   = req_payload.opcode inside {OP_WR_BYTE, OP_WR_HALF, OP_WR_WORD};
      is_half = req_payload.opcode inside {OP_RD_HALF, OP_WR_HALF};
      is_word = req_payload.opcode inside {OP_RD_WORD, OP_WR_WORD};
      is_sum  = (req_payload.opcode == OP_CHECKSUM);

      if (!(is_rd || is_wr)) begin
         acc_status = STAT_OK;
      end else if (req_payload.addr_in >= MEM_LIMIT) begin
         acc_status = STAT_OOB;
      end else if ((is_half && req_payload.addr_in[0])
                   || (is_word && (req_payload.addr_in[1:0] != 2'b00))) begin
         acc_status = STAT_MISALIGNED;
      end else if ((is_half && (req_payload.addr_in > LIM_HALF))
                   || (is_word && (req_payload.addr_in > LIM_WORD))) begin
         acc_status = STAT_OOB;
      end else begin
         acc_status = STAT_OK;
      end

      lane = ~req_payload.addr_in[1:0];
      if (is_word) begin
         acc_be   = 4'b1111;
         acc_data = req_payload.write_value;
      end else if (is_half) begin
         acc_be   = req_payload.addr_in[1] ? 4'b0011 : 4'b1100;
         acc_data = {2{req_payload.write_value[15:0]}};
      end else begin
         acc_be   = 4'b0001 << lane;
         acc_data = {4{req_payload.write_value[7:0]}};
      end

      if (is_word) begin
         rd_size_in = SZ_WORD;
      end else if (is_half) begin
         rd_size_in = SZ_HALF;
      end else begin
         rd_size_in = SZ_BYTE;
      end
      rd_off_in = req_payload.addr_in[1:0];
   end

   always_comb begin
      logic [1:0] rd_lane;
      rd_lane = ~rd_off_ff;
      case (rd_size_ff)
         SZ_WORD: rd_value = ram_rd_data;
         SZ_HALF: rd_value = {16'd0, rd_off_ff[1] ? ram_rd_data[15:0] : ram_rd_data[31:16]};
         default: rd_value = {24'd0, ram_rd_data[8*rd_lane +: 8]};
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clear_row_in   = clear_row_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      sum_start      = 1'b0;

      ram_wr_en   = 1'b0;
      ram_wr_row  = req_payload.addr_in[RW+1:2];
      ram_wr_be   = acc_be;
      ram_wr_data = acc_data;
      ram_rd_en   = 1'b0;
      ram_rd_row  = req_payload.addr_in[RW+1:2];

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_row   = clear_row_ff;
            ram_wr_be    = 4'b1111;
            ram_wr_data  = '0;
            clear_row_in = clear_row_ff + RW'(1);
            if (clear_row_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (is_sum) begin
                  sum_start = 1'b1;
                  state_in  = S_SUM;
               end else if (is_rd && (acc_status == STAT_OK)) begin
                  ram_rd_en = 1'b1;
                  state_in  = S_READ;
               end else begin
                  ram_wr_en      = is_wr && (acc_status == STAT_OK);
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '{read_value: '0, status: acc_status};
               end
            end
         end
         S_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{read_value: rd_value, status: STAT_OK};
            state_in       = S_IDLE;
         end
         S_SUM: begin
            ram_rd_en  = sum_rd_en;
            ram_rd_row = sum_rd_row;
            if (sum_ctl.done) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{read_value: sum_value, status: STAT_OK};
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (req_fire) begin
         rd_size_ff <= rd_size_in;
         rd_off_ff  <= rd_off_in;
      end
   end

   bma_ram #(
      .ROWS (ROWS),
      .RW   (RW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_row  (ram_wr_row),
      .wr_be   (ram_wr_be),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_row  (ram_rd_row),
      .rd_data (ram_rd_data)
   );

   bma_sum #(
      .MEM_BYTES (MEM_BYTES),
      .ROWS      (ROWS),
      .RW        (RW)
   ) u_sum (
      .clock   (clock),
      .reset   (reset),
      .start   (sum_start),
      .rd_data (ram_rd_data),
      .rd_en   (sum_rd_en),
      .rd_row  (sum_rd_row),
      .ctl     (sum_ctl),
      .sum     (sum_value)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `BMA_ASSERT_NOW(a_read_slot_free, state_ff == S_READ, !rsp_valid_ff, "read with output held")
   `BMA_ASSERT_NOW(a_sum_in_flight, state_ff == S_SUM, sum_ctl.busy, "sweep lost in flight")
   `BMA_ASSERT_NEXT(a_write_answers, req_fire && is_wr, rsp_valid_ff && (state_ff == S_IDLE), "write gave no response")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bma_pkg::*;

   localparam int          MEM_BYTES       = MEM_BYTES_DEFAULT;
   localparam logic [2:0]  OP_UNUSED       = 3'd7;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          CYCLE_LIMIT     = 600000;
   localparam int          RANDOM_PHASES   = 4;
   localparam int          PHASE_ITEMS     = 175;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   logic [7:0] mem_image [MEM_BYTES];
   rsp_type    pending_results [$];
   int         errors = 0;
   int         cycle_count = 0;
   bit         tx_gaps = 1'b1;
   bit         rx_stalls = 1'b1;
   bit         hold_off_pending = 1'b0;

   byte_memory_with_sized_access #(.MEM_BYTES(MEM_BYTES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic int unsigned access_bytes(logic [2:0] op);
      case (op)
         OP_RD_BYTE, OP_WR_BYTE: return 1;
         OP_RD_HALF, OP_WR_HALF: return 2;
         OP_RD_WORD, OP_WR_WORD: return 4;
         default:                return 0;
      endcase
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type          res;
      int unsigned      len;
      longint unsigned  a;
      logic [31:0]      sum;
      res = '0;
      res.status = STAT_OK;
      len = access_bytes(r.opcode);
      a = longint'(r.addr_in);
      if (r.opcode == OP_CHECKSUM) begin
         sum = '0;
         for (int i = 0; i < MEM_BYTES; i++)
            sum = sum + ({24'b0, mem_image[i]} ^ i);
         res.read_value = sum;
      end else if (len != 0) begin
         if (a >= MEM_BYTES)
            res.status = STAT_OOB;
         else if ((a & (len - 1)) != 0)
            res.status = STAT_MISALIGNED;
         else if (a + len > MEM_BYTES)
            res.status = STAT_OOB;
         else if (r.opcode == OP_RD_BYTE || r.opcode == OP_RD_HALF ||
                  r.opcode == OP_RD_WORD) begin
            for (int k = 0; k < len; k++)
               res.read_value = (res.read_value << 8) | mem_image[int'(a) + k];
         end else begin
            for (int k = 0; k < len; k++)
               mem_image[int'(a) + k] = 8'(r.write_value >> (8 * (len - 1 - k)));
         end
      end
      return res;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [31:0] a, logic [31:0] d);
      req_type r;
      r.opcode = op;
      r.addr_in = a;
      r.write_value = d;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 199);
      if (pick < 3)
         r.opcode = OP_CHECKSUM;
      else if (pick < 5)
         r.opcode = OP_UNUSED;
      else begin
         case ($urandom_range(0, 5))
            0:       r.opcode = OP_RD_BYTE;
            1:       r.opcode = OP_RD_HALF;
            2:       r.opcode = OP_RD_WORD;
            3:       r.opcode = OP_WR_BYTE;
            4:       r.opcode = OP_WR_HALF;
            default: r.opcode = OP_WR_WORD;
         endcase
      end
      len = access_bytes(r.opcode);
      pick = $urandom_range(0, 99);
      if (pick < 8)
         r.addr_in = $urandom() | MEM_BYTES;
      else if (pick < 12)
         r.addr_in = MEM_BYTES - 8 + $urandom_range(0, 15);
      else if (pick < 35)
         r.addr_in = $urandom_range(0, 63);
      else if (pick < 55)
         r.addr_in = MEM_BYTES - 64 + $urandom_range(0, 63);
      else
         r.addr_in = $urandom_range(0, MEM_BYTES - 1);
      if (pick >= 12 && len > 1 && $urandom_range(0, 9) < 8)
         r.addr_in = r.addr_in & ~(len - 1);
      r.write_value = $urandom();
      return r;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      gap = (tx_gaps && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left == 0 && rx_stalls && $urandom_range(0, 4) == 0)
            stall_left = gap_length();
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h/%0d", $realtime,
                        rsp_payload.read_value, rsp_payload.status);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %h actual %h", $realtime,
                           want.read_value, rsp_payload.read_value);
                  errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           want.status, rsp_payload.status);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(predict_access(req_payload));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** byte_memory_with_sized_access: FAILED **");
         $finish;
      end
   end

   task automatic test_cleared_memory();
      send_request(make_req(OP_CHECKSUM, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(OP_RD_WORD, 32'h0, 32'hFFFF_FFFF));
      send_request(make_req(OP_RD_BYTE, MEM_BYTES - 1, 32'h0));
      drain_results();
   endtask

   task automatic test_sized_access_edges();
      send_request(make_req(OP_WR_WORD, 32'h0, 32'hFFFF_FFFF));
      send_request(make_req(OP_RD_WORD, 32'h0, 32'h0));
      send_request(make_req(OP_RD_HALF, 32'h2, 32'h0));
      send_request(make_req(OP_RD_BYTE, 32'h3, 32'h0));
      send_request(make_req(OP_WR_HALF, MEM_BYTES - 2, 32'h1234_A5C3));
      send_request(make_req(OP_RD_HALF, MEM_BYTES - 2, 32'h0));
      send_request(make_req(OP_WR_BYTE, MEM_BYTES - 1, 32'hFFFF_FF80));
      send_request(make_req(OP_RD_WORD, MEM_BYTES - 4, 32'h0));
      send_request(make_req(OP_WR_WORD, MEM_BYTES - 4, 32'h8000_0001));
      send_request(make_req(OP_RD_HALF, 32'h1, 32'h0));
      send_request(make_req(OP_WR_WORD, 32'h2, 32'h5555_AAAA));
      send_request(make_req(OP_RD_WORD, 32'h0, 32'h0));
      send_request(make_req(OP_WR_BYTE, MEM_BYTES, 32'h0000_00FF));
      send_request(make_req(OP_RD_WORD, 32'hFFFF_FFFC, 32'h0));
      send_request(make_req(OP_WR_HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(OP_UNUSED, 32'h0, 32'hFFFF_FFFF));
      send_request(make_req(OP_CHECKSUM, 32'h0, 32'h0));
      drain_results();
   endtask

   task automatic test_back_pressure();
      tx_gaps = 1'b0;
      hold_off_pending = 1'b1;
      repeat (40) send_request(random_request());
      drain_results();
      tx_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         tx_gaps = p[0];
         rx_stalls = p[1];
         repeat (PHASE_ITEMS) send_request(random_request());
      end
      drain_results();
   endtask

   initial begin
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_cleared_memory();
      test_sized_access_edges();
      test_back_pressure();
      test_random_traffic();
      if (errors == 0)
         $display("** byte_memory_with_sized_access: PASSED **");
      else
         $display("** byte_memory_with_sized_access: FAILED **");
      $finish;
   end

endmodule
